FILE: rtl/core/ccse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccse_pkg
// Shared types, codes and constants of the cell charge state estimator:
// phase codes, register indexes, reset values, the per-cell record and
// the segment constants of the voltage-to-charge table.
// ----------------------------------------------------------------------------
package ccse_pkg;

  localparam logic [2:0] PH_INIT    = 3'd0;
  localparam logic [2:0] PH_TRANS   = 3'd1;
  localparam logic [2:0] PH_CHARGE  = 3'd2;
  localparam logic [2:0] PH_DISCHG  = 3'd3;
  localparam logic [2:0] PH_REST    = 3'd4;
  localparam logic [2:0] PH_FULL    = 3'd5;
  localparam logic [2:0] PH_EMPTY   = 3'd6;

  localparam logic [2:0] CFG_ZERO_BAND   = 3'd0;
  localparam logic [2:0] CFG_DONE_CUR    = 3'd1;
  localparam logic [2:0] CFG_VOLT_BAND   = 3'd2;
  localparam logic [2:0] CFG_COUNT_LIMIT = 3'd3;
  localparam logic [2:0] CFG_FULL_VOLT   = 3'd4;
  localparam logic [2:0] CFG_EMPTY_VOLT  = 3'd5;
  localparam logic [2:0] CFG_GAIN        = 3'd6;

  localparam logic [14:0] RST_ZERO_BAND   = 15'd50;
  localparam logic [14:0] RST_DONE_CUR    = 15'd50;
  localparam logic [15:0] RST_VOLT_BAND   = 16'd10;
  localparam logic [15:0] RST_COUNT_LIMIT = 16'd500;
  localparam logic [15:0] RST_FULL_VOLT   = 16'd42000;
  localparam logic [15:0] RST_EMPTY_VOLT  = 16'd25000;
  localparam logic [15:0] RST_GAIN        = 16'd1820;

  localparam logic signed [31:0] Q_HUNDRED = 32'sd6553600;

  typedef struct packed {
    logic [2:0]         phase;
    logic signed [31:0] charge;
    logic signed [31:0] health;
    logic signed [31:0] depth;
    logic [15:0]        prev_volt;
    logic [15:0]        steady_cnt;
  } entry_t;

  // Table segment i runs from SEG_VOLT[i] to SEG_VOLT[i+1]. The division by the
  // segment width is done as a shift, then a reciprocal multiply by 2^31/div.
  localparam logic [15:0] SEG_VOLT [8] = '{16'd0, 16'd25000, 16'd28000, 16'd30000,
                                           16'd33000, 16'd36000, 16'd40000, 16'd42000};
  localparam logic [22:0] SEG_SOC_BASE [8] = '{23'd0, 23'd0, 23'd471859, 23'd760218,
                                               23'd2280653, 23'd4082893, 23'd6553600,
                                               23'd6553600};
  localparam logic [21:0] SEG_SOC_DELTA [8] = '{22'd0, 22'd471859, 22'd288359, 22'd1520435,
                                                22'd1802240, 22'd2470707, 22'd0, 22'd0};
  localparam logic [2:0] SEG_SHIFT [8] = '{3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd5, 3'd4, 3'd3};
  localparam logic [8:0] SEG_DIV [8] = '{9'd375, 9'd375, 9'd125, 9'd375,
                                         9'd375, 9'd125, 9'd125, 9'd375};
  localparam logic [24:0] SEG_RECIP [8] = '{25'd5726623, 25'd5726623, 25'd17179869,
                                            25'd5726623, 25'd5726623, 25'd17179869,
                                            25'd17179869, 25'd5726623};

  function automatic logic [2:0] seg_of(input logic [15:0] volt);
    logic [2:0] s;
    s = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (volt <= SEG_VOLT[i + 1]) s = 3'(i);
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ccse_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccse_if
// Channel interfaces of the cell charge state estimator: measurement
// requests, results and configuration writes, each with valid and ready.
// ----------------------------------------------------------------------------
interface ccse_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         cell_req;
  logic signed [15:0] current;
  logic [15:0]        voltage;

  modport source (output valid, output action, output cell_req, output current,
                  output voltage, input ready);
  modport sink (input valid, input action, input cell_req, input current,
                input voltage, output ready);
endinterface

interface ccse_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cell_out;
  logic [2:0]         phase;
  logic signed [31:0] charge_level;
  logic signed [31:0] health_level;
  logic signed [31:0] depth_level;

  modport source (output valid, output cell_out, output phase, output charge_level,
                  output health_level, output depth_level, input ready);
  modport sink (input valid, input cell_out, input phase, input charge_level,
                input health_level, input depth_level, output ready);
endinterface

interface ccse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ccse_ocv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccse_ocv
// Open-circuit voltage to charge lookup. Piecewise-linear interpolation,
// rounded down, in a three-stage pipeline; the result is formed
// combinationally from the registers of the third stage.
// ----------------------------------------------------------------------------
module ccse_ocv (
  input  logic               clk,
  input  logic [15:0]        volt_i,
  output logic signed [31:0] soc_o
);

  logic [2:0]  seg_in;
  logic [15:0] dv;
  logic [2:0]  seg1_r;
  logic [37:0] num1_r;
  logic [30:0] x2;
  logic [2:0]  seg2_r;
  logic [30:0] x2_r;
  logic [55:0] pm2_r;
  logic [24:0] q0;
  logic [2:0]  seg3_r;
  logic [30:0] x3_r;
  logic [24:0] q03_r;
  logic [33:0] qb3_r;
  logic [33:0] rem;
  logic [25:0] quot;

  assign seg_in = ccse_pkg::seg_of(volt_i);
  assign dv     = volt_i - ccse_pkg::SEG_VOLT[seg_in];
  assign x2     = 31'(num1_r >> ccse_pkg::SEG_SHIFT[seg1_r]);
  assign q0     = pm2_r[55:31];

  always_ff @(posedge clk) begin
    seg1_r <= seg_in;
    num1_r <= 38'(dv * ccse_pkg::SEG_SOC_DELTA[seg_in]);
    seg2_r <= seg1_r;
    x2_r   <= x2;
    pm2_r  <= 56'(x2 * ccse_pkg::SEG_RECIP[seg1_r]);
    seg3_r <= seg2_r;
    x3_r   <= x2_r;
    q03_r  <= q0;
    qb3_r  <= 34'(q0 * ccse_pkg::SEG_DIV[seg2_r]);
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign rem   = {3'b000, x3_r} - qb3_r;
  assign quot  = {1'b0, q03_r} + ((rem >= {25'd0, ccse_pkg::SEG_DIV[seg3_r]}) ? 26'd1 : 26'd0);
  assign soc_o = $signed({9'd0, ccse_pkg::SEG_SOC_BASE[seg3_r]}) + $signed({6'd0, quot});

endmodule
`default_nettype wire

FILE: rtl/core/cell_charge_state_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_charge_state_estimator
// Per-cell state of charge, health and depth of discharge estimator.
//
// in_ch carries one measurement per transaction: an init or update action,
// the cell index, the pack current and the cell voltage. Every transaction
// on in_ch yields exactly one transaction on out_ch with the cell's phase
// and its charge, health and depth in Q16.16 percent. cfg_ch writes the
// seven tuning registers and is always ready; the user must write it only
// while idle, as the block does not enforce this. Cell records live in one
// memory, one entry per cell, read and written back once per in-range
// transaction. Valid bits, cleared at reset, make unwritten cells read as
// zero in the initial phase, so reset needs no clearing pass. A transaction
// is accepted in the idle step; the record and the voltage table come back
// through the memory read and the three-stage table divider, the update is
// computed in the calc step and written back while the result loads the
// output register; out_ch turns valid in the same cycle as in_ch turns ready.
// If out_ch stalls, the result waits in the output register and a further
// finished result waits in the final step until the register frees up.
// ----------------------------------------------------------------------------
module cell_charge_state_estimator #(
  parameter int CELLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ccse_in_if.sink     in_ch,
  ccse_out_if.source  out_ch,
  ccse_cfg_if.sink    cfg_ch
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0]  state_r, state_nxt;

  logic [14:0] zband_r, cdone_r;
  logic [15:0] vband_r, slimit_r, vfull_r, vempty_r, gain_r;

  logic                in_acc, in_range, out_load, mem_we;
  logic [AW+3:0]       req_ext;
  logic [AW-1:0]       addr_in;

  logic                act_r, inr_r;
  logic [3:0]          cell_r;
  logic [AW-1:0]       addr_r;
  logic signed [15:0]  cur_r;
  logic [15:0]         volt_r;
  logic signed [32:0]  coul_r;

  ccse_pkg::entry_t    mem [CELLS];
  ccse_pkg::entry_t    rd_data_r;
  logic                rd_valid_r;
  logic [CELLS-1:0]    valid_r;
  ccse_pkg::entry_t    ent, upd_nxt, upd_r;

  logic signed [31:0]  soc;

  logic                out_valid_r;
  logic [3:0]          out_cell_r;
  logic [2:0]          out_phase_r;
  logic signed [31:0]  out_chg_r, out_hlt_r, out_dep_r;

  logic signed [16:0]  cur_x, zb, cb;
  logic                gt_z, lt_nz, gt_nz, lt_z, gt_ncb;
  logic signed [16:0]  delta;
  logic signed [31:0]  dep_c, chg_c, dep_t;
  logic signed [17:0]  vdiff, vb;
  logic                steady;
  logic [15:0]         cnt_new;

  ccse_ocv u_ocv (
    .clk    (clk),
    .volt_i (in_ch.voltage),
    .soc_o  (soc)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign req_ext      = {{AW{1'b0}}, in_ch.cell_req};
  assign addr_in      = req_ext[AW-1:0];
  assign in_range     = ({28'd0, in_ch.cell_req} < 32'(CELLS));
  assign out_load     = (state_r == ST_WRITE) && (!out_valid_r || out_ch.ready);
  assign mem_we       = out_load && inr_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_WRITE;
      ST_WRITE: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      zband_r     <= ccse_pkg::RST_ZERO_BAND;
      cdone_r     <= ccse_pkg::RST_DONE_CUR;
      vband_r     <= ccse_pkg::RST_VOLT_BAND;
      slimit_r    <= ccse_pkg::RST_COUNT_LIMIT;
      vfull_r     <= ccse_pkg::RST_FULL_VOLT;
      vempty_r    <= ccse_pkg::RST_EMPTY_VOLT;
      gain_r      <= ccse_pkg::RST_GAIN;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (mem_we) valid_r[addr_r] <= 1'b1;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          ccse_pkg::CFG_ZERO_BAND:   zband_r  <= cfg_ch.data[14:0];
          ccse_pkg::CFG_DONE_CUR:    cdone_r  <= cfg_ch.data[14:0];
          ccse_pkg::CFG_VOLT_BAND:   vband_r  <= cfg_ch.data;
          ccse_pkg::CFG_COUNT_LIMIT: slimit_r <= cfg_ch.data;
          ccse_pkg::CFG_FULL_VOLT:   vfull_r  <= cfg_ch.data;
          ccse_pkg::CFG_EMPTY_VOLT:  vempty_r <= cfg_ch.data;
          ccse_pkg::CFG_GAIN:        gain_r   <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_ch.action;
      cell_r <= in_ch.cell_req;
      addr_r <= addr_in;
      inr_r  <= in_range;
      cur_r  <= in_ch.current;
      volt_r <= in_ch.voltage;
      coul_r <= 33'(in_ch.current * $signed({1'b0, gain_r}));
    end
    if (state_r == ST_CALC) upd_r <= upd_nxt;
    if (out_load) begin
      out_cell_r  <= cell_r;
      out_phase_r <= inr_r ? upd_r.phase : 3'd0;
      out_chg_r   <= inr_r ? upd_r.charge : 32'sd0;
      out_hlt_r   <= inr_r ? upd_r.health : 32'sd0;
      out_dep_r   <= inr_r ? upd_r.depth : 32'sd0;
    end
  end

  // Record memory. One transaction is in flight at a time, so a read never
  // overlaps the write-back of the same cell.
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= upd_r;
    if (in_acc && in_range) begin
      rd_data_r  <= mem[addr_in];
      rd_valid_r <= valid_r[addr_in];
    end
  end

  assign ent    = rd_valid_r ? rd_data_r : '0;
  assign cur_x  = {cur_r[15], cur_r};
  assign zb     = $signed({2'b00, zband_r});
  assign cb     = $signed({2'b00, cdone_r});
  assign gt_z   = cur_x > zb;
  assign lt_z   = cur_x < zb;
  assign lt_nz  = cur_x < -zb;
  assign gt_nz  = cur_x > -zb;
  assign gt_ncb = cur_x > -cb;

  assign delta = coul_r[32:16];
  assign dep_c = ccse_pkg::sat32(34'(ent.depth) + 34'(delta));
  assign chg_c = ccse_pkg::sat32(34'(ent.health) - 34'(dep_c));
  assign dep_t = ccse_pkg::sat32(34'(act_r ? ent.health : ccse_pkg::Q_HUNDRED) - 34'(soc));

  assign vdiff  = $signed({2'b00, volt_r}) - $signed({2'b00, ent.prev_volt});
  assign vb     = $signed({2'b00, vband_r});
  assign steady = (vdiff <= vb) && (vdiff >= -vb);
  assign cnt_new = !steady ? 16'd0 :
                   (ent.steady_cnt == 16'hffff) ? ent.steady_cnt : ent.steady_cnt + 16'd1;

  always_comb begin
    upd_nxt           = ent;
    upd_nxt.prev_volt = volt_r;
    if (!act_r) begin
      upd_nxt.phase  = ccse_pkg::PH_INIT;
      upd_nxt.health = ccse_pkg::Q_HUNDRED;
      upd_nxt.charge = soc;
      upd_nxt.depth  = dep_t;
    end else begin
      unique case (ent.phase)
        ccse_pkg::PH_INIT: begin
          if (gt_z) upd_nxt.phase = ccse_pkg::PH_DISCHG;
          else if (lt_nz) upd_nxt.phase = ccse_pkg::PH_CHARGE;
          else upd_nxt.phase = ccse_pkg::PH_TRANS;
        end
        ccse_pkg::PH_TRANS: begin
          if (gt_z) upd_nxt.phase = ccse_pkg::PH_DISCHG;
          else if (lt_nz) upd_nxt.phase = ccse_pkg::PH_CHARGE;
          else begin
            upd_nxt.steady_cnt = cnt_new;
            if (cnt_new >= slimit_r) upd_nxt.phase = ccse_pkg::PH_REST;
          end
        end
        ccse_pkg::PH_CHARGE: begin
          if (gt_z) upd_nxt.phase = ccse_pkg::PH_DISCHG;
          else if (gt_nz) upd_nxt.phase = ccse_pkg::PH_TRANS;
          else if (gt_ncb || (volt_r >= vfull_r)) upd_nxt.phase = ccse_pkg::PH_FULL;
          else begin
            upd_nxt.depth  = dep_c;
            upd_nxt.charge = chg_c;
          end
        end
        ccse_pkg::PH_DISCHG: begin
          if (lt_nz) upd_nxt.phase = ccse_pkg::PH_CHARGE;
          else if (lt_z) upd_nxt.phase = ccse_pkg::PH_TRANS;
          else if (volt_r <= vempty_r) upd_nxt.phase = ccse_pkg::PH_EMPTY;
          else begin
            upd_nxt.depth  = dep_c;
            upd_nxt.charge = chg_c;
          end
        end
        ccse_pkg::PH_REST: begin
          if (gt_z) upd_nxt.phase = ccse_pkg::PH_DISCHG;
          else if (lt_nz) upd_nxt.phase = ccse_pkg::PH_CHARGE;
          else begin
            upd_nxt.charge = soc;
            upd_nxt.depth  = dep_t;
          end
        end
        ccse_pkg::PH_FULL: begin
          upd_nxt.health = ent.charge;
          if (gt_z) upd_nxt.phase = ccse_pkg::PH_DISCHG;
          else if (gt_nz) upd_nxt.phase = ccse_pkg::PH_TRANS;
        end
        ccse_pkg::PH_EMPTY: begin
          upd_nxt.health = ent.depth;
          if (lt_nz) upd_nxt.phase = ccse_pkg::PH_CHARGE;
          else if (lt_z) upd_nxt.phase = ccse_pkg::PH_TRANS;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cell_out     = out_cell_r;
  assign out_ch.phase        = out_phase_r;
  assign out_ch.charge_level = out_chg_r;
  assign out_ch.health_level = out_hlt_r;
  assign out_ch.depth_level  = out_dep_r;

  a_we_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> inr_r && (state_r == ST_WRITE))
    else $error("record write for a cell outside the memory");

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (upd_r.phase <= ccse_pkg::PH_EMPTY))
    else $error("unused phase code written back");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) && out_valid_r && !out_ch.ready |=> (state_r == ST_WRITE))
    else $error("finished transaction left the final step while the output was full");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_READ) ##1 (state_r == ST_WAIT) ##1 (state_r == ST_CALC))
    else $error("transaction sequence broken after acceptance");

endmodule
`default_nettype wire

FILE: verif/cell_charge_state_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_charge_state_estimator_tb
// Self-checking testbench of the cell charge state estimator. A behavioral
// model of every cell's phase, charge, health and depth of discharge
// predicts each result from the accepted measurement transactions, and a
// checker compares every result transaction field by field, in order.
// Directed tests walk the phase machine and the voltage table knots, then
// random bursts under several register settings and idling patterns run,
// with one long output stall that fills the block and backs up its input.
// ----------------------------------------------------------------------------
module cell_charge_state_estimator_tb;

  localparam int NUM_CELLS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int VOLT_KNOT [9] = '{0, 25000, 28000, 30000, 33000, 36000, 40000, 42000,
                                   100000};
  localparam int SOC_KNOT [9] = '{0, 0, 471859, 760218, 2280653, 4082893, 6553600,
                                  6553600, 6553600};

  typedef struct {
    logic [3:0]         cell_idx;
    logic [2:0]         phase;
    logic signed [31:0] charge;
    logic signed [31:0] health;
    logic signed [31:0] depth;
  } cell_report_t;

  logic clk;
  logic rst_n;

  ccse_in_if  in_ch();
  ccse_out_if out_ch();
  ccse_cfg_if cfg_ch();

  cell_charge_state_estimator #(.CELLS(NUM_CELLS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [14:0] zero_band;
  logic [14:0] done_current;
  logic [15:0] steady_band;
  logic [15:0] steady_limit;
  logic [15:0] full_volt;
  logic [15:0] empty_volt;
  logic [15:0] gain;

  logic [2:0]  phase_of  [NUM_CELLS];
  int          charge_of [NUM_CELLS];
  int          health_of [NUM_CELLS];
  int          depth_of  [NUM_CELLS];
  logic [15:0] last_volt [NUM_CELLS];
  int          steady_of [NUM_CELLS];

  cell_report_t pending_reports[$];
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int current_mode;

  always #5 clk = ~clk;

  function automatic int clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic int ocv_charge(input logic [15:0] volt);
    int seg;
    longint dv;
    longint ds;
    seg = 7;
    for (int i = 0; i < 7 && seg == 7; i++) begin
      if (int'(volt) <= VOLT_KNOT[i + 1]) seg = i;
    end
    dv = longint'(volt) - VOLT_KNOT[seg];
    ds = longint'(SOC_KNOT[seg + 1]) - SOC_KNOT[seg];
    return int'(SOC_KNOT[seg] + (dv * ds) / (VOLT_KNOT[seg + 1] - VOLT_KNOT[seg]));
  endfunction

  task automatic apply_ocv(input int c, input logic [15:0] volt);
    charge_of[c] = ocv_charge(volt);
    depth_of[c] = clamp32(longint'(health_of[c]) - charge_of[c]);
  endtask

  task automatic apply_coulombs(input int c, input int cur);
    longint step;
    step = (longint'(cur) * longint'(gain)) >>> 16;
    depth_of[c] = clamp32(longint'(depth_of[c]) + step);
    charge_of[c] = clamp32(longint'(health_of[c]) - depth_of[c]);
  endtask

  task automatic advance_cell_estimate(input logic act, input logic [3:0] cell_idx,
                                       input logic signed [15:0] cur_raw,
                                       input logic [15:0] volt);
    int c;
    int cur;
    int zb;
    int cb;
    int d;
    cell_report_t rep;
    c = int'(cell_idx);
    cur = int'(cur_raw);
    zb = int'(zero_band);
    cb = int'(done_current);
    if (act == 1'b0) begin
      phase_of[c] = ccse_pkg::PH_INIT;
      health_of[c] = ccse_pkg::Q_HUNDRED;
      apply_ocv(c, volt);
    end else begin
      case (phase_of[c])
        ccse_pkg::PH_INIT: begin
          if (cur > zb) phase_of[c] = ccse_pkg::PH_DISCHG;
          else if (cur < -zb) phase_of[c] = ccse_pkg::PH_CHARGE;
          else phase_of[c] = ccse_pkg::PH_TRANS;
        end
        ccse_pkg::PH_TRANS: begin
          if (cur > zb) phase_of[c] = ccse_pkg::PH_DISCHG;
          else if (cur < -zb) phase_of[c] = ccse_pkg::PH_CHARGE;
          else begin
            d = int'(volt) - int'(last_volt[c]);
            if (d <= int'(steady_band) && d >= -int'(steady_band)) begin
              if (steady_of[c] < 65535) steady_of[c]++;
            end else begin
              steady_of[c] = 0;
            end
            if (steady_of[c] >= int'(steady_limit)) phase_of[c] = ccse_pkg::PH_REST;
          end
        end
        ccse_pkg::PH_CHARGE: begin
          if (cur > zb) phase_of[c] = ccse_pkg::PH_DISCHG;
          else if (cur > -zb) phase_of[c] = ccse_pkg::PH_TRANS;
          else if (cur > -cb || volt >= full_volt) phase_of[c] = ccse_pkg::PH_FULL;
          else apply_coulombs(c, cur);
        end
        ccse_pkg::PH_DISCHG: begin
          if (cur < -zb) phase_of[c] = ccse_pkg::PH_CHARGE;
          else if (cur < zb) phase_of[c] = ccse_pkg::PH_TRANS;
          else if (volt <= empty_volt) phase_of[c] = ccse_pkg::PH_EMPTY;
          else apply_coulombs(c, cur);
        end
        ccse_pkg::PH_REST: begin
          if (cur > zb) phase_of[c] = ccse_pkg::PH_DISCHG;
          else if (cur < -zb) phase_of[c] = ccse_pkg::PH_CHARGE;
          else apply_ocv(c, volt);
        end
        ccse_pkg::PH_FULL: begin
          health_of[c] = charge_of[c];
          if (cur > zb) phase_of[c] = ccse_pkg::PH_DISCHG;
          else if (cur > -zb) phase_of[c] = ccse_pkg::PH_TRANS;
        end
        ccse_pkg::PH_EMPTY: begin
          health_of[c] = depth_of[c];
          if (cur < -zb) phase_of[c] = ccse_pkg::PH_CHARGE;
          else if (cur < zb) phase_of[c] = ccse_pkg::PH_TRANS;
        end
        default: ;
      endcase
    end
    last_volt[c] = volt;
    rep.cell_idx = cell_idx;
    rep.phase = phase_of[c];
    rep.charge = charge_of[c];
    rep.health = health_of[c];
    rep.depth = depth_of[c];
    pending_reports.push_back(rep);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input int c);
    if (got != want)
      report_mismatch($sformatf("cell %0d %s got %0d expected %0d", c, name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    cell_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result for cell %0d", out_ch.cell_out));
      end else begin
        want = pending_reports.pop_front();
        check_field("cell", int'(out_ch.cell_out), int'(want.cell_idx), want.cell_idx);
        check_field("phase", int'(out_ch.phase), int'(want.phase), want.cell_idx);
        check_field("charge", out_ch.charge_level, want.charge, want.cell_idx);
        check_field("health", out_ch.health_level, want.health, want.cell_idx);
        check_field("depth", out_ch.depth_level, want.depth, want.cell_idx);
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_measurement(input logic act, input logic [3:0] cell_idx,
                                  input logic signed [15:0] cur,
                                  input logic [15:0] volt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.cell_req = cell_idx;
    in_ch.current = cur;
    in_ch.voltage = volt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_cell_estimate(act, cell_idx, cur, volt);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ccse_pkg::CFG_ZERO_BAND:   zero_band = value[14:0];
      ccse_pkg::CFG_DONE_CUR:    done_current = value[14:0];
      ccse_pkg::CFG_VOLT_BAND:   steady_band = value;
      ccse_pkg::CFG_COUNT_LIMIT: steady_limit = value;
      ccse_pkg::CFG_FULL_VOLT:   full_volt = value;
      ccse_pkg::CFG_EMPTY_VOLT:  empty_volt = value;
      ccse_pkg::CFG_GAIN:        gain = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] zb, input logic [15:0] cb,
                                input logic [15:0] vb, input logic [15:0] lim,
                                input logic [15:0] fv, input logic [15:0] ev,
                                input logic [15:0] g);
    write_register(ccse_pkg::CFG_ZERO_BAND, zb);
    write_register(ccse_pkg::CFG_DONE_CUR, cb);
    write_register(ccse_pkg::CFG_VOLT_BAND, vb);
    write_register(ccse_pkg::CFG_COUNT_LIMIT, lim);
    write_register(ccse_pkg::CFG_FULL_VOLT, fv);
    write_register(ccse_pkg::CFG_EMPTY_VOLT, ev);
    write_register(ccse_pkg::CFG_GAIN, g);
  endtask

  function automatic logic signed [15:0] pick_current();
    int zb;
    int cb;
    int mag;
    zb = int'(zero_band);
    cb = int'(done_current);
    if ($urandom_range(0, 3) == 0) current_mode = $urandom_range(0, 9);
    case (current_mode)
      0, 1, 2: begin
        mag = $urandom_range(0, zb);
        return 16'($urandom_range(0, 1) ? mag : -mag);
      end
      3, 4: return 16'(-int'($urandom_range(zb + 1, 32768)));
      5, 6: return 16'($urandom_range(zb + 1, 32767));
      7: return 16'(-int'($urandom_range(zb + 1, (cb > zb) ? cb : zb + 1)));
      8: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_voltage(input logic [3:0] cell_idx);
    int b;
    int v;
    b = (int'(steady_band) < 40) ? int'(steady_band) : 40;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'(last_volt[cell_idx]) + int'($urandom_range(0, 2 * b)) - b;
      5, 6: v = $urandom_range(0, 65535);
      7: v = int'(full_volt) + int'($urandom_range(0, 200)) - 100;
      8: v = int'(empty_volt) + int'($urandom_range(0, 200)) - 100;
      default: v = $urandom_range(25000, 42000);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic test_directed_phases();
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd0);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd25000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd26500);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd28000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd30000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd33000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd36000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd40000);
    send_measurement(1'b0, 4'd0, 16'sd0, 16'd42000);
    send_measurement(1'b0, 4'd0, 16'sh7fff, 16'd65535);
    send_measurement(1'b0, 4'd15, 16'sd0, 16'd36000);
    send_measurement(1'b1, 4'd15, 16'sh7fff, 16'd36000);
    send_measurement(1'b1, 4'd15, 16'sh7fff, 16'd35000);
    send_measurement(1'b1, 4'd15, 16'sd1000, 16'd25000);
    send_measurement(1'b1, 4'd15, 16'sd0, 16'd25000);
    send_measurement(1'b1, 4'd15, 16'sd0, 16'd25005);
    send_measurement(1'b0, 4'd5, 16'sd0, 16'd30000);
    send_measurement(1'b1, 4'd5, 16'sh8000, 16'd30000);
    send_measurement(1'b1, 4'd5, 16'sh8000, 16'd35000);
    send_measurement(1'b1, 4'd5, -16'sd3000, 16'd42000);
    send_measurement(1'b1, 4'd5, -16'sd3000, 16'd42000);
    send_measurement(1'b1, 4'd5, 16'sd100, 16'd41000);
    send_measurement(1'b0, 4'd9, 16'sd0, 16'd33000);
    send_measurement(1'b1, 4'd9, 16'sd0, 16'd33000);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    apply_settings(16'd32767, 16'd32767, 16'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
    send_measurement(1'b0, 4'd3, 16'sd0, 16'd33000);
    send_measurement(1'b1, 4'd3, 16'sd0, 16'd33000);
    send_measurement(1'b1, 4'd3, 16'sd100, 16'd34000);
    send_measurement(1'b1, 4'd3, 16'sd5, 16'd35000);
    send_measurement(1'b1, 4'd3, 16'sh8000, 16'd35000);
    send_measurement(1'b1, 4'd3, 16'sh8000, 16'd35000);
    send_measurement(1'b1, 4'd3, 16'sh8000, 16'd65535);
    send_measurement(1'b1, 4'd3, 16'sh7fff, 16'd0);
    wait_drain();
  endtask

  task automatic test_random(input int items);
    int sent;
    int burst;
    logic [3:0] c;
    sent = 0;
    while (sent < items) begin
      c = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
        send_measurement(1'($urandom_range(0, 1)), c, 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          send_measurement(1'b0, c, 16'($urandom), pick_voltage(c));
          sent++;
        end
        current_mode = $urandom_range(0, 9);
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send_measurement(1'b1, c, pick_current(), pick_voltage(c));
          sent++;
        end
      end
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    hold_left = 300;
    repeat (16) begin
      send_measurement(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                       16'($urandom), 16'($urandom));
    end
    wait_drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.cell_req = 4'd0;
    in_ch.current = 16'sd0;
    in_ch.voltage = 16'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ccse_pkg::CFG_ZERO_BAND;
    cfg_ch.data = 16'd0;
    mismatch_count = 0;
    hold_left = 0;
    current_mode = 0;
    send_idle_pct = 33;
    recv_idle_pct = 57;
    zero_band = ccse_pkg::RST_ZERO_BAND;
    done_current = ccse_pkg::RST_DONE_CUR;
    steady_band = ccse_pkg::RST_VOLT_BAND;
    steady_limit = ccse_pkg::RST_COUNT_LIMIT;
    full_volt = ccse_pkg::RST_FULL_VOLT;
    empty_volt = ccse_pkg::RST_EMPTY_VOLT;
    gain = ccse_pkg::RST_GAIN;
    for (int i = 0; i < NUM_CELLS; i++) begin
      phase_of[i] = ccse_pkg::PH_INIT;
      charge_of[i] = 0;
      health_of[i] = 0;
      depth_of[i] = 0;
      last_volt[i] = 16'd0;
      steady_of[i] = 0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed_phases();
    test_register_extremes();
    apply_settings(16'd50, 16'd300, 16'd20, 16'd4, 16'd42000, 16'd25000, 16'd1820);
    test_random(230);
    test_output_backpressure();

    send_idle_pct = 57;
    recv_idle_pct = 33;
    apply_settings(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)), 16'd65535,
                   16'd1, 16'd65535, 16'd0, 16'd65535);
    test_random(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(16'd0, 16'd0, 16'd0, 16'd2, 16'd38000, 16'd30000, 16'd0);
    test_random(110);
    apply_settings(16'($urandom_range(0, 500)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 50)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(38000, 44000)), 16'($urandom_range(24000, 30000)),
                   16'($urandom_range(0, 65535)));
    test_random(110);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
